/* rtl/artifact_container_parser_unit_defines.svh */
// ============================================================================
// Assertion macros for the container parser
// Shared concurrent assertion forms, clocked on the rising edge and held off
// during reset.
// ============================================================================
`ifndef ARTIFACT_CONTAINER_PARSER_UNIT_DEFINES_SVH
`define ARTIFACT_CONTAINER_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define ACP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ACP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/acp_pkg.sv */
// ============================================================================
// acp_pkg
// Types, section codes, status codes and magic words of the container parser.
// ============================================================================
package acp_pkg;

    // Section / parse phase codes
    localparam logic [4:0] PH_MAGIC      = 5'd0;
    localparam logic [4:0] PH_VER        = 5'd1;
    localparam logic [4:0] PH_STR1_LEN   = 5'd2;
    localparam logic [4:0] PH_STR1_BYTES = 5'd3;
    localparam logic [4:0] PH_STR2_LEN   = 5'd4;
    localparam logic [4:0] PH_STR2_BYTES = 5'd5;
    localparam logic [4:0] PH_STR3_LEN   = 5'd6;
    localparam logic [4:0] PH_STR3_BYTES = 5'd7;
    localparam logic [4:0] PH_MODE       = 5'd8;
    localparam logic [4:0] PH_FP         = 5'd9;
    localparam logic [4:0] PH_CNT        = 5'd10;
    localparam logic [4:0] PH_ENT        = 5'd11;
    localparam logic [4:0] PH_OLEN       = 5'd12;
    localparam logic [4:0] PH_OBJ        = 5'd13;
    localparam logic [4:0] PH_ECNT       = 5'd14;
    localparam logic [4:0] PH_TAG        = 5'd15;
    localparam logic [4:0] PH_PLEN       = 5'd16;
    localparam logic [4:0] PH_PAY        = 5'd17;
    localparam logic [4:0] PH_FOOT       = 5'd18;
    localparam logic [4:0] PH_DONE       = 5'd19;

    // Status codes
    localparam logic [3:0] STATUS_RUNNING   = 4'd0;
    localparam logic [3:0] STATUS_ACCEPTED  = 4'd1;
    localparam logic [3:0] STATUS_MAGIC     = 4'd2;
    localparam logic [3:0] STATUS_VERSION   = 4'd3;
    localparam logic [3:0] STATUS_MODE      = 4'd4;
    localparam logic [3:0] STATUS_FP        = 4'd5;
    localparam logic [3:0] STATUS_ZERO      = 4'd6;
    localparam logic [3:0] STATUS_SINGLE    = 4'd7;
    localparam logic [3:0] STATUS_FOOTER    = 4'd8;
    localparam logic [3:0] STATUS_TRUNCATED = 4'd9;
    localparam logic [3:0] STATUS_TRAILING  = 4'd10;

    // Magic words as little-endian 32-bit values
    localparam logic [31:0] HEAD_MAGIC_LE = 32'h4143_4A46;
    localparam logic [31:0] FOOT_MAGIC_LE = 32'h4543_4A46;

    // Configuration port
    localparam int unsigned   CFG_ADDR_W            = 3;
    localparam logic          CFG_IDX_EXP_VERSION   = 1'b0;
    localparam logic [31:0]   EXP_VERSION_RESET     = 32'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } beat_t;

    typedef struct packed {
        logic [4:0]  section;
        logic [7:0]  byte_out;
        logic        value_ready;
        logic [63:0] value;
        logic [3:0]  status;
        logic        frame_end;
    } result_t;

endpackage

/* rtl/acp_cfg.sv */
// ============================================================================
// acp_cfg
// APB-style register file holding the accepted format version.
// ============================================================================
module acp_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [acp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [31:0]                     expected_version
);
    import acp_pkg::*;

    logic [31:0] exp_version_reg;
    logic        word_idx;

    assign word_idx = paddr[CFG_ADDR_W-1];
    assign pready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exp_version_reg <= EXP_VERSION_RESET;
        end else if (psel && penable && pwrite && (word_idx == CFG_IDX_EXP_VERSION)) begin
            exp_version_reg <= pwdata;
        end
    end

    assign prdata           = (word_idx == CFG_IDX_EXP_VERSION) ? exp_version_reg : 32'd0;
    assign expected_version = exp_version_reg;

endmodule

/* rtl/acp_parser.sv */
// ============================================================================
// acp_parser
// Parse state registers and the per-beat next-state / result logic.
// ============================================================================
module acp_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  acp_pkg::beat_t      beat,
    input  logic [31:0]         expected_version,
    output acp_pkg::result_t    result
);
    import acp_pkg::*;

    logic [4:0]  phase_reg,   phase_next;
    logic [2:0]  idx_reg,     idx_next;
    logic [63:0] acc_reg,     acc_next;
    logic [63:0] rem_reg,     rem_next;
    logic [31:0] ent_reg,     ent_next;
    logic [31:0] ext_reg,     ext_next;
    logic        single_reg,  single_next;
    logic [3:0]  latch_reg,   latch_next;

    // state as seen by this beat (first byte restarts)
    logic [4:0]  ph;
    logic [2:0]  k;
    logic [63:0] acc, rem, gacc, rem_dec;
    logic [31:0] ent, ext, ent_dec, ext_dec;
    logic        single;
    logic [3:0]  latch;
    logic        gdone, gather_en;
    logic [3:0]  err;
    logic [7:0]  b;

    always_comb begin
        b      = beat.data_byte;
        ph     = beat.first_byte ? PH_MAGIC : phase_reg;
        k      = beat.first_byte ? 3'd0     : idx_reg;
        acc    = beat.first_byte ? 64'd0    : acc_reg;
        rem    = beat.first_byte ? 64'd0    : rem_reg;
        ent    = beat.first_byte ? 32'd0    : ent_reg;
        ext    = beat.first_byte ? 32'd0    : ext_reg;
        single = beat.first_byte ? 1'b0     : single_reg;
        latch  = beat.first_byte ? STATUS_RUNNING : latch_reg;

        gacc    = acc | ({56'd0, b} << {k, 3'b000});
        gdone   = (ph == PH_OLEN) ? (k == 3'd7) : (k >= 3'd3);
        rem_dec = rem - 64'd1;
        ent_dec = ent - 32'd1;
        ext_dec = ext - 32'd1;

        result.section     = ph;
        result.byte_out    = 8'd0;
        result.value_ready = 1'b0;
        result.value       = 64'd0;
        result.status      = STATUS_RUNNING;
        result.frame_end   = beat.last_byte;

        err         = STATUS_RUNNING;
        gather_en   = 1'b0;
        phase_next  = ph;
        rem_next    = rem;
        ent_next    = ent;
        ext_next    = ext;
        single_next = single;
        latch_next  = latch;

        unique case (ph)
            PH_MAGIC, PH_FOOT: begin
                gather_en = 1'b1;
                if (gdone) begin
                    if (ph == PH_MAGIC) begin
                        if (gacc != {32'd0, HEAD_MAGIC_LE}) err = STATUS_MAGIC;
                        phase_next = PH_VER;
                    end else begin
                        if (gacc != {32'd0, FOOT_MAGIC_LE}) err = STATUS_FOOTER;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_VER: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    if (gacc != {32'd0, expected_version}) err = STATUS_VERSION;
                    else phase_next = PH_STR1_LEN;
                end
            end
            PH_STR1_LEN, PH_STR2_LEN, PH_STR3_LEN: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    if (gacc == 64'd0) begin
                        phase_next = ph + 5'd2;
                    end else begin
                        rem_next   = gacc;
                        phase_next = ph + 5'd1;
                    end
                end
            end
            PH_STR1_BYTES, PH_STR2_BYTES, PH_STR3_BYTES: begin
                result.byte_out = b;
                rem_next        = rem_dec;
                if (rem_dec == 64'd0) phase_next = ph + 5'd1;
            end
            PH_MODE: begin
                result.value_ready = 1'b1;
                result.value       = {56'd0, b};
                if (b > 8'd1) begin
                    err = STATUS_MODE;
                end else begin
                    single_next = (b == 8'd0);
                    phase_next  = PH_FP;
                end
            end
            PH_FP: begin
                result.value_ready = 1'b1;
                result.value       = {56'd0, b};
                if (b > 8'd1) err = STATUS_FP;
                else phase_next = PH_CNT;
            end
            PH_CNT: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    if (gacc == 64'd0) begin
                        err = STATUS_ZERO;
                    end else if (single && (gacc != 64'd1)) begin
                        err = STATUS_SINGLE;
                    end else begin
                        ent_next   = gacc[31:0];
                        phase_next = PH_ENT;
                    end
                end
            end
            PH_ENT: begin
                result.byte_out = b;
                ent_next        = ent_dec;
                if (ent_dec == 32'd0) phase_next = PH_OLEN;
            end
            PH_OLEN: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    if (gacc == 64'd0) begin
                        phase_next = PH_ECNT;
                    end else begin
                        rem_next   = gacc;
                        phase_next = PH_OBJ;
                    end
                end
            end
            PH_OBJ: begin
                result.byte_out = b;
                rem_next        = rem_dec;
                if (rem_dec == 64'd0) phase_next = PH_ECNT;
            end
            PH_ECNT: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    if (gacc == 64'd0) begin
                        phase_next = PH_FOOT;
                    end else begin
                        ext_next   = gacc[31:0];
                        phase_next = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    ext_next           = ext_dec;
                    phase_next         = PH_PLEN;
                end
            end
            PH_PLEN: begin
                gather_en = 1'b1;
                if (gdone) begin
                    result.value_ready = 1'b1;
                    result.value       = gacc;
                    if (gacc == 64'd0) begin
                        phase_next = (ext != 32'd0) ? PH_TAG : PH_FOOT;
                    end else begin
                        rem_next   = gacc;
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                result.byte_out = b;
                rem_next        = rem_dec;
                if (rem_dec == 64'd0) phase_next = (ext != 32'd0) ? PH_TAG : PH_FOOT;
            end
            default: begin
                // beyond footer, after an error, or an unused code
                result.section = PH_DONE;
                phase_next     = PH_DONE;
                if (latch == STATUS_RUNNING) latch_next = STATUS_TRAILING;
            end
        endcase

        if (!gather_en) begin
            idx_next = k;
            acc_next = acc;
        end else if (gdone) begin
            idx_next = 3'd0;
            acc_next = 64'd0;
        end else begin
            idx_next = k + 3'd1;
            acc_next = gacc;
        end

        if (err != STATUS_RUNNING) begin
            latch_next = err;
            phase_next = PH_DONE;
        end

        priority if (latch_next != STATUS_RUNNING) begin
            result.status = latch_next;
        end else if (phase_next == PH_DONE) begin
            result.status = beat.last_byte ? STATUS_ACCEPTED : STATUS_RUNNING;
        end else if (beat.last_byte) begin
            latch_next    = STATUS_TRUNCATED;
            phase_next    = PH_DONE;
            result.status = STATUS_TRUNCATED;
        end else begin
            result.status = STATUS_RUNNING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_MAGIC;
            idx_reg    <= 3'd0;
            acc_reg    <= 64'd0;
            rem_reg    <= 64'd0;
            ent_reg    <= 32'd0;
            ext_reg    <= 32'd0;
            single_reg <= 1'b0;
            latch_reg  <= STATUS_RUNNING;
        end else if (advance) begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            ent_reg    <= ent_next;
            ext_reg    <= ext_next;
            single_reg <= single_next;
            latch_reg  <= latch_next;
        end
    end

endmodule

/* rtl/artifact_container_parser_unit.sv */
// ============================================================================
// artifact_container_parser_unit
// Streaming container parser: tags each byte with its section, reports
// little-endian numeric fields and latches sticky error codes.
// ============================================================================
//
//  channel | dir | handshake          | beat contents
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_valid / s_ready  | data_byte, first_byte, last_byte
//  m_      | out | m_valid / m_ready  | section, byte_out, value_ready, value,
//          |     |                    | status, frame_end
//  apb     | in  | psel/penable/pready| expected_version at byte address 0
//
//  Flow: one beat per cycle while m_ready holds. A beat is held in the input
//  register, the parse state updating in one pass, then in the result register.
//  Stalls: while a result waits on m_ready, s_ready stays high only while the
//  input register is empty, so two beats are held before the input stalls.
//  Reset (aresetn low, synchronous) empties both registers, clears the parse
//  state and sets expected_version to 1.
//
`include "artifact_container_parser_unit_defines.svh"

module artifact_container_parser_unit (
    input  logic                            aclk,
    input  logic                            aresetn,

    // input byte channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_first_byte,
    input  logic                            s_last_byte,

    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [4:0]                      m_section,
    output logic [7:0]                      m_byte_out,
    output logic                            m_value_ready,
    output logic [63:0]                     m_value,
    output logic [3:0]                      m_status,
    output logic                            m_frame_end,

    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [acp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import acp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    beat_t       in_beat_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     out_result_reg;
    result_t     step_result;
    logic        advance;
    logic        s_take;
    logic [31:0] expected_version;

    // assertion helpers
    logic        end_beat;
    logic        done_beat;
    logic        pass_beat;
    logic        has_code;
    logic        byte_section;

    // ---- configuration registers
    acp_cfg u_cfg (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .expected_version (expected_version)
    );

    // ---- flow control
    // The held beat moves into the parser when the result register is
    // empty or being drained this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // ---- input register (payload unreset)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_beat_reg.data_byte  <= s_data_byte;
            in_beat_reg.first_byte <= s_first_byte;
            in_beat_reg.last_byte  <= s_last_byte;
        end
    end

    // ---- parse step: state update and result for the held beat
    acp_parser u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .advance          (advance),
        .beat             (in_beat_reg),
        .expected_version (expected_version),
        .result           (step_result)
    );

    // ---- result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_section     = out_result_reg.section;
    assign m_byte_out    = out_result_reg.byte_out;
    assign m_value_ready = out_result_reg.value_ready;
    assign m_value       = out_result_reg.value;
    assign m_status      = out_result_reg.status;
    assign m_frame_end   = out_result_reg.frame_end;

    // ---- assertions
    assign end_beat     = m_valid && m_frame_end;
    assign done_beat    = m_valid && (m_section == PH_DONE);
    assign pass_beat    = m_valid && (m_byte_out != 8'd0);
    assign has_code     = (m_status != STATUS_RUNNING);
    assign byte_section = (m_section == PH_STR1_BYTES) || (m_section == PH_STR2_BYTES) ||
                          (m_section == PH_STR3_BYTES) || (m_section == PH_ENT) ||
                          (m_section == PH_OBJ) || (m_section == PH_PAY);

    // The final beat of a blob always carries a verdict.
    `ACP_ASSERT_NOW(a_frame_end_verdict, aclk, aresetn, end_beat, has_code, "no final status")
    // Beyond-footer beats always carry a latched code.
    `ACP_ASSERT_NOW(a_done_has_code, aclk, aresetn, done_beat, has_code, "no latched code")
    // Pass-through bytes appear only in byte sections.
    `ACP_ASSERT_NOW(a_byte_out_section, aclk, aresetn, pass_beat, byte_section, "stray byte_out")
    // A beat moved into the parser shows up as a result next cycle.
    `ACP_ASSERT_NEXT(a_advance_loads, aclk, aresetn, advance, m_valid, "parsed beat lost")

endmodule

/* bench/tb.sv */
// ============================================================================
// Container parser testbench
// Streams container blobs through the parser one byte per beat and checks
// every result beat against a cycle-free model of the parse walk. Blobs are
// well formed with random content or carry one planted fault. The fault
// kinds are bad magic, bad version, bad mode, bad fp mode, zero count,
// single-mode count, bad footer, cut short, trailing bytes and restart in
// mid-blob. Random noise bytes are mixed in. The version register is set
// to several values between runs.
// ============================================================================
module tb;
    import acp_pkg::*;

    // Watchdog: cycles without any beat moving before the run is called hung.
    localparam int IDLE_LIMIT = 4000;
    // Long receiver hold-off used to back the parser up.
    localparam int LONG_HOLD  = 300;
    localparam logic [CFG_ADDR_W-1:0] ADDR_EXP_VERSION = {CFG_IDX_EXP_VERSION, 2'b00};

    typedef logic [7:0] octet_t;

    // What is planted in a generated blob.
    typedef enum int {
        FLT_NONE,
        FLT_MAGIC,
        FLT_VERSION,
        FLT_MODE,
        FLT_FP,
        FLT_ZERO,
        FLT_SINGLE,
        FLT_FOOTER,
        FLT_TRUNC,
        FLT_TRAIL,
        FLT_RESTART
    } fault_e;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_data_byte  = '0;
    logic                  s_first_byte = 1'b0;
    logic                  s_last_byte  = 1'b0;

    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic [4:0]            m_section;
    logic [7:0]            m_byte_out;
    logic                  m_value_ready;
    logic [63:0]           m_value;
    logic [3:0]            m_status;
    logic                  m_frame_end;

    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [31:0]           pwdata       = '0;
    logic [31:0]           prdata;
    logic                  pready;

    artifact_container_parser_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data_byte   (s_data_byte),
        .s_first_byte  (s_first_byte),
        .s_last_byte   (s_last_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_section     (m_section),
        .m_byte_out    (m_byte_out),
        .m_value_ready (m_value_ready),
        .m_value       (m_value),
        .m_status      (m_status),
        .m_frame_end   (m_frame_end),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    beat_t   bytes_pending[$];  // beats waiting for the driver
    result_t results_due[$];    // predicted results, oldest first
    int      beats_queued  = 0;
    int      results_seen  = 0;
    int      err_count     = 0;
    int      quiet_cycles  = 0;
    bit      beat_taken    = 1'b0; // set at the edge that accepts an input beat
    bit      idle_on       = 1'b0; // random gaps on both sides
    int      hold_request  = 0;    // long receiver hold-off, picked up by the receiver
    int      tx_gap        = 0;
    int      rx_wait       = 0;

    // Parse state of the model, same widths as the block's state.
    logic [4:0]  pp_phase;
    logic [2:0]  pp_idx;
    logic [63:0] pp_acc;
    logic [63:0] pp_left;
    logic [31:0] pp_entries;
    logic [31:0] pp_exts;
    logic        pp_single;
    logic [3:0]  pp_err;
    logic [31:0] cfg_version;

    // ------------------------------------------------------------------------
    // Parse model
    // ------------------------------------------------------------------------
    function automatic void parser_restart();
        pp_phase   = PH_MAGIC;
        pp_idx     = '0;
        pp_acc     = '0;
        pp_left    = '0;
        pp_entries = '0;
        pp_exts    = '0;
        pp_single  = 1'b0;
        pp_err     = STATUS_RUNNING;
    endfunction

    // Shift one byte into a little-endian field of n bytes; 1 when complete.
    function automatic logic take_le(input logic [7:0] b, input int n,
                                     output logic [63:0] v);
        logic [2:0] k;
        k      = pp_idx;
        v      = '0;
        pp_acc = pp_acc | (64'(b) << (8 * k));
        if (int'(k) + 1 >= n) begin
            v      = pp_acc;
            pp_acc = '0;
            pp_idx = '0;
            return 1'b1;
        end
        pp_idx = k + 3'd1;
        return 1'b0;
    endfunction

    function automatic logic [4:0] after_record();
        return (pp_exts != 0) ? PH_TAG : PH_FOOT;
    endfunction

    // Advance the model by one byte and return the result beat it should give.
    function automatic result_t parse_byte(input beat_t bt);
        result_t     r;
        logic [63:0] v;
        logic [3:0]  found;
        logic [7:0]  b;
        b     = bt.data_byte;
        r     = '0;
        found = STATUS_RUNNING;
        if (bt.first_byte)
            parser_restart();
        r.section = pp_phase;

        case (pp_phase)
            PH_MAGIC, PH_FOOT: begin
                // magic words are judged only once all four bytes are in
                if (take_le(b, 4, v)) begin
                    if (pp_phase == PH_MAGIC) begin
                        if (v[31:0] != HEAD_MAGIC_LE) found = STATUS_MAGIC;
                        pp_phase = PH_VER;
                    end else begin
                        if (v[31:0] != FOOT_MAGIC_LE) found = STATUS_FOOTER;
                        pp_phase = PH_DONE;
                    end
                end
            end
            PH_VER: begin
                if (take_le(b, 4, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    if (v != {32'd0, cfg_version}) found = STATUS_VERSION;
                    else pp_phase = PH_STR1_LEN;
                end
            end
            PH_STR1_LEN, PH_STR2_LEN, PH_STR3_LEN: begin
                if (take_le(b, 4, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    // empty string: skip its byte section
                    if (v == 0) begin
                        pp_phase = pp_phase + 5'd2;
                    end else begin
                        pp_left  = v;
                        pp_phase = pp_phase + 5'd1;
                    end
                end
            end
            PH_STR1_BYTES, PH_STR2_BYTES, PH_STR3_BYTES: begin
                r.byte_out = b;
                pp_left    = pp_left - 64'd1;
                if (pp_left == 0) pp_phase = pp_phase + 5'd1;
            end
            PH_MODE: begin
                r.value_ready = 1'b1;
                r.value       = 64'(b);
                if (b > 8'd1) begin
                    found = STATUS_MODE;
                end else begin
                    pp_single = (b == 8'd0);
                    pp_phase  = PH_FP;
                end
            end
            PH_FP: begin
                r.value_ready = 1'b1;
                r.value       = 64'(b);
                if (b > 8'd1) found = STATUS_FP;
                else pp_phase = PH_CNT;
            end
            PH_CNT: begin
                if (take_le(b, 4, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    if (v == 0) begin
                        found = STATUS_ZERO;
                    end else if (pp_single && v != 1) begin
                        found = STATUS_SINGLE;
                    end else begin
                        pp_entries = v[31:0];
                        pp_phase   = PH_ENT;
                    end
                end
            end
            PH_ENT: begin
                r.byte_out = b;
                pp_entries = pp_entries - 32'd1;
                if (pp_entries == 0) pp_phase = PH_OLEN;
            end
            PH_OLEN: begin
                if (take_le(b, 8, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    if (v == 0) begin
                        pp_phase = PH_ECNT;
                    end else begin
                        pp_left  = v;
                        pp_phase = PH_OBJ;
                    end
                end
            end
            PH_OBJ: begin
                r.byte_out = b;
                pp_left    = pp_left - 64'd1;
                if (pp_left == 0) pp_phase = PH_ECNT;
            end
            PH_ECNT: begin
                if (take_le(b, 4, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    if (v == 0) begin
                        pp_phase = PH_FOOT;
                    end else begin
                        pp_exts  = v[31:0];
                        pp_phase = PH_TAG;
                    end
                end
            end
            PH_TAG: begin
                if (take_le(b, 4, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    pp_exts       = pp_exts - 32'd1;
                    pp_phase      = PH_PLEN;
                end
            end
            PH_PLEN: begin
                if (take_le(b, 4, v)) begin
                    r.value_ready = 1'b1;
                    r.value       = v;
                    if (v == 0) begin
                        pp_phase = after_record();
                    end else begin
                        pp_left  = v;
                        pp_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                r.byte_out = b;
                pp_left    = pp_left - 64'd1;
                if (pp_left == 0) pp_phase = after_record();
            end
            default: begin
                // past the footer or after an error; unused codes land here too
                r.section = PH_DONE;
                pp_phase  = PH_DONE;
                if (pp_err == STATUS_RUNNING) pp_err = STATUS_TRAILING;
            end
        endcase

        // sticky error handling, then accept / truncation on the last byte
        if (found != STATUS_RUNNING) begin
            pp_err   = found;
            pp_phase = PH_DONE;
        end
        if (pp_err != STATUS_RUNNING) begin
            r.status = pp_err;
        end else if (pp_phase == PH_DONE) begin
            r.status = bt.last_byte ? STATUS_ACCEPTED : STATUS_RUNNING;
        end else if (bt.last_byte) begin
            pp_err   = STATUS_TRUNCATED;
            pp_phase = PH_DONE;
            r.status = STATUS_TRUNCATED;
        end
        r.frame_end = bt.last_byte;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        err_count++;
        $display("tb: mismatch on %s, result beat %0d: got %0h want %0h",
                 what, results_seen, got, want);
    endtask

    // Mostly short idle stretches, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: checks result beats, predicts accepted input beats, watchdog.
    // Everything is sampled at the rising edge; the driver side changes only
    // at the falling edge.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        result_t want;
        beat_t   bt;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result beat", m_value, '0);
                end else begin
                    want = results_due.pop_front();
                    if (m_section !== want.section)
                        report_mismatch("section", m_section, want.section);
                    if (m_byte_out !== want.byte_out)
                        report_mismatch("byte_out", m_byte_out, want.byte_out);
                    if (m_value_ready !== want.value_ready)
                        report_mismatch("value_ready", m_value_ready, want.value_ready);
                    if (m_value !== want.value)
                        report_mismatch("value", m_value, want.value);
                    if (m_status !== want.status)
                        report_mismatch("status", m_status, want.status);
                    if (m_frame_end !== want.frame_end)
                        report_mismatch("frame_end", m_frame_end, want.frame_end);
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                bt.data_byte  = s_data_byte;
                bt.first_byte = s_first_byte;
                bt.last_byte  = s_last_byte;
                results_due.insert(results_due.size(), parse_byte(bt));
                beat_taken = 1'b1;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("tb: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: offers queued beats, holds each until accepted.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : driver
        logic  nv;
        beat_t bt;
        nv = s_valid;
        if (beat_taken) begin
            nv         = 1'b0;
            beat_taken = 1'b0;
        end
        if (!nv && aresetn) begin
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (bytes_pending.size() != 0) begin
                bt = bytes_pending.pop_front();
                s_data_byte  <= bt.data_byte;
                s_first_byte <= bt.first_byte;
                s_last_byte  <= bt.last_byte;
                nv = 1'b1;
                if (idle_on && $urandom_range(0, 2) == 0) tx_gap = pick_gap();
            end
        end
        s_valid <= nv;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus the long hold-off on request.
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        if (hold_request != 0) begin
            rx_wait      = hold_request;
            hold_request = 0;
        end else if (rx_wait == 0 && idle_on && $urandom_range(0, 3) == 0) begin
            rx_wait = pick_gap();
        end
        if (rx_wait != 0) begin
            m_ready <= 1'b0;
            rx_wait--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_beat(input logic [7:0] b, input logic first, input logic last);
        beat_t bt;
        bt.data_byte  = b;
        bt.first_byte = first;
        bt.last_byte  = last;
        bytes_pending.insert(bytes_pending.size(), bt);
        beats_queued++;
    endtask

    task automatic add_le(ref octet_t img[$], input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            img.insert(img.size(), v[8*i +: 8]);
    endtask

    task automatic add_random(ref octet_t img[$], input int n);
        repeat (n) img.insert(img.size(), 8'($urandom()));
    endtask

    // Lengths stay small; zero is frequent so the skip paths get hit.
    function automatic logic [31:0] short_len();
        if ($urandom_range(0, 3) == 0) return 32'd0;
        return 32'($urandom_range(1, 4));
    endfunction

    // Build one blob image with the given fault planted in it.
    task automatic make_image(input fault_e f, ref octet_t img[$]);
        logic [31:0] ver, len, cnt, n_ext;
        logic [63:0] olen;
        logic [7:0]  mode, fpm;
        int          idx;
        img.delete();

        add_le(img, 64'(HEAD_MAGIC_LE), 4);
        if (f == FLT_MAGIC) begin
            idx      = $urandom_range(0, 3);
            img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
        end

        ver = cfg_version;
        if (f == FLT_VERSION) ver = ver ^ ($urandom() | (32'd1 << $urandom_range(0, 31)));
        add_le(img, 64'(ver), 4);

        for (int i = 0; i < 3; i++) begin
            len = short_len();
            add_le(img, 64'(len), 4);
            add_random(img, int'(len));
        end

        if (f == FLT_SINGLE)    mode = 8'd0;
        else if (f == FLT_MODE) mode = 8'($urandom_range(2, 255));
        else                    mode = 8'($urandom_range(0, 1));
        fpm = (f == FLT_FP) ? 8'($urandom_range(2, 255)) : 8'($urandom_range(0, 1));
        img.insert(img.size(), mode);
        img.insert(img.size(), fpm);

        // single mode allows exactly one entry
        if (f == FLT_ZERO) begin
            cnt = 32'd0;
        end else if (f == FLT_SINGLE) begin
            cnt = $urandom();
            if (cnt < 2) cnt = 32'd2;
        end else begin
            cnt = (mode == 8'd0) ? 32'd1 : 32'($urandom_range(1, 4));
        end
        add_le(img, 64'(cnt), 4);
        add_random(img, (cnt > 4) ? 4 : int'(cnt));

        // a huge object only makes sense in a blob that never finishes
        if ((f == FLT_TRUNC || f == FLT_RESTART) && $urandom_range(0, 1) == 1) begin
            olen = {$urandom(), $urandom()} | 64'h1_0000_0000;
            add_le(img, olen, 8);
            add_random(img, $urandom_range(0, 5));
            return;
        end
        olen = 64'(short_len());
        add_le(img, olen, 8);
        add_random(img, int'(olen));

        n_ext = 32'($urandom_range(0, 2));
        add_le(img, 64'(n_ext), 4);
        repeat (n_ext) begin
            add_le(img, 64'($urandom()), 4);
            len = short_len();
            add_le(img, 64'(len), 4);
            add_random(img, int'(len));
        end

        add_le(img, 64'(FOOT_MAGIC_LE), 4);
        if (f == FLT_FOOTER) begin
            idx      = img.size() - 1 - $urandom_range(0, 3);
            img[idx] = img[idx] ^ 8'($urandom_range(1, 255));
        end
    endtask

    // Queue an image: cut short, run on past the end, or left open for a restart.
    task automatic send_image(input fault_e f, ref octet_t img[$]);
        int cut, n;
        cut = img.size();
        if (f == FLT_TRUNC)        cut = $urandom_range(1, img.size() - 1);
        else if (f == FLT_RESTART) cut = $urandom_range(1, img.size());
        for (int i = 0; i < cut; i++)
            push_beat(img[i], i == 0,
                      (i == cut - 1) && f != FLT_RESTART && f != FLT_TRAIL);
        if (f == FLT_TRAIL) begin
            n = $urandom_range(1, 3);
            for (int j = 0; j < n; j++)
                push_beat(8'($urandom()), 1'b0, j == n - 1);
        end
    endtask

    // Wait until every queued beat has been sent and every result has come.
    task automatic drain();
        while (bytes_pending.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Register write followed by a readback; only called with the parser idle.
    task automatic write_version(input logic [31:0] ver);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_EXP_VERSION;
        pwdata  <= ver;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        cfg_version = ver;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== ver) report_mismatch("version readback", prdata, ver);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // A mix of well-formed blobs, faulted blobs and loose noise bytes.
    task automatic feed_random(input int goal, input bit with_hold);
        octet_t img[$];
        fault_e f;
        int     start, n;
        start = beats_queued;
        while (beats_queued - start < goal) begin
            if ($urandom_range(0, 19) == 0) begin
                n = $urandom_range(1, 6);
                repeat (n)
                    push_beat(8'($urandom()), $urandom_range(0, 7) == 0,
                              $urandom_range(0, 7) == 0);
            end else begin
                if ($urandom_range(0, 99) < 45) f = FLT_NONE;
                else f = fault_e'($urandom_range(int'(FLT_MAGIC), int'(FLT_RESTART)));
                make_image(f, img);
                send_image(f, img);
            end
            // halfway through, let the queue run low and then stall the
            // receiver for a long stretch while the sender keeps offering
            if (with_hold && beats_queued - start >= goal / 2) begin
                while (bytes_pending.size() > 40) @(posedge aclk);
                hold_request = LONG_HOLD;
                with_hold    = 1'b0;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        octet_t img[$];
        parser_restart();
        cfg_version = EXP_VERSION_RESET;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: bytes before any first-byte flag parse as a blob from reset.
        img.delete();
        add_le(img, 64'(HEAD_MAGIC_LE), 4);
        add_le(img, 64'(EXP_VERSION_RESET), 4);
        foreach (img[i]) push_beat(img[i], 1'b0, 1'b0);
        push_beat(8'hFF, 1'b0, 1'b0);          // into the first string length
        push_beat(8'h00, 1'b1, 1'b1);          // restart mid-blob, one-byte blob: cut short
        push_beat(8'hFF, 1'b0, 1'b0);          // after the error: latched code
        // wrong header magic, found only on the fourth byte
        repeat (4) push_beat(8'hFF, $urandom_range(0, 0) == 0 && beats_queued == 11, 1'b0);
        push_beat(8'h00, 1'b0, 1'b1);
        // good magic, version all ones against the reset value
        img.delete();
        add_le(img, 64'(HEAD_MAGIC_LE), 4);
        add_le(img, 64'hFFFF_FFFF, 4);
        foreach (img[i]) push_beat(img[i], i == 0, 1'b0);
        push_beat(8'h80, 1'b0, 1'b1);
        drain();

        // Every fault kind once, version register at its top value.
        write_version(32'hFFFF_FFFF);
        idle_on = 1'b1;
        for (int k = int'(FLT_NONE); k <= int'(FLT_RESTART); k++) begin
            make_image(fault_e'(k), img);
            send_image(fault_e'(k), img);
        end
        drain();

        // Random traffic with idling and one long receiver hold-off.
        write_version(32'h0000_0000);
        feed_random(300, 1'b1);
        drain();

        // Back-to-back stretch, no idling on either side.
        write_version($urandom());
        idle_on = 1'b0;
        feed_random(300, 1'b0);
        drain();

        write_version(EXP_VERSION_RESET);
        idle_on = 1'b1;
        feed_random(300, 1'b0);
        drain();
        repeat (8) @(posedge aclk);

        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
